[design/bmv_pkg.sv]
package bmv_pkg;

   // field widths of the stream items
   localparam int SAMPLE_W   = 16;
   localparam int VAR_W      = 32;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = 2;

   // input item selector
   typedef enum logic {
      ACTION_SAMPLE = 1'b0,
      ACTION_FINISH = 1'b1
   } action_type;

   // result item kind
   typedef enum logic {
      KIND_BLOCK = 1'b0,
      KIND_TOTAL = 1'b1
   } kind_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAPTURE,
      ST_LOAD,
      ST_DIVIDE,
      ST_EMIT
   } bmv_state_type;

   // controller to datapath
   typedef struct packed {
      logic accum;
      logic clear_block;
      logic capture;
      logic load_block;
      logic load_final;
      logic step;
      logic emit;
   } bmv_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic block_full;
      logic no_blocks;
      logic rsp_free;
   } bmv_status_type;

   // dividend width shared by the dividers and the step counter
   function automatic int bmv_div_width(input int block_size, input int max_blocks);
      int sum_w;
      int tot_w;
      sum_w = SAMPLE_W + $clog2(block_size + 1);
      tot_w = VAR_W + $clog2(max_blocks + 1);
      return (2 * sum_w > tot_w) ? 2 * sum_w : tot_w;
   endfunction

endpackage

[design/bmv_divider.sv]
module bmv_divider #(
   parameter int DIV_W = 41,
   parameter int DVS_W = 9
) (
   input  logic             clock,
   input  logic             load,
   input  logic             step,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient
);

   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] rem_in;
   logic [DIV_W-1:0] quo_ff;
   logic [DIV_W-1:0] quo_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W-1:0] dvs_in;
   logic [DVS_W:0]   shifted;
   logic             fits;

   // one restoring step per cycle while step is set, quotient bits shift in from the right
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (load) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (step) begin
         rem_in = fits ? DVS_W'(shifted - {1'b0, dvs_ff}) : DVS_W'(shifted);
         quo_in = {quo_ff[DIV_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;

endmodule

[design/bmv_datapath.sv]
module bmv_datapath import bmv_pkg::*; #(
   parameter int BLOCK_SIZE = 9,
   parameter int MAX_BLOCKS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  bmv_cmd_type           cmd,
   output bmv_status_type        status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int LOG_N   = $clog2(BLOCK_SIZE + 1);
   localparam int LOG_B   = $clog2(MAX_BLOCKS + 1);
   localparam int POS_W   = $clog2(BLOCK_SIZE);
   localparam int SUM_W   = SAMPLE_W + LOG_N;
   localparam int SQ_W    = 2 * SAMPLE_W - 2 + LOG_N;
   localparam int PROD_W  = 2 * SUM_W;
   localparam int TOT_W   = VAR_W + LOG_B;
   localparam int MTOT_W  = SAMPLE_W + LOG_B;
   localparam int DIV_W   = bmv_div_width(BLOCK_SIZE, MAX_BLOCKS);
   localparam int N_SQ    = BLOCK_SIZE * BLOCK_SIZE;
   localparam int N_NM1   = BLOCK_SIZE * (BLOCK_SIZE - 1);
   localparam int DVS_W   = ($clog2(N_SQ + 1) > LOG_B) ? $clog2(N_SQ + 1) : LOG_B;

   // block accumulators
   logic        [POS_W-1:0]  pos_ff, pos_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic        [SQ_W-1:0]   sq_ff, sq_in;
   logic signed [SAMPLE_W-1:0]   sample;
   logic signed [2*SAMPLE_W-1:0] sample_sq;

   // block end capture
   logic [SUM_W-1:0]  mag_ff;
   logic              neg_ff;
   logic [PROD_W-1:0] ssq_ff;
   logic [PROD_W-1:0] nsq_ff;
   logic [PROD_W-1:0] diff;

   // totals over blocks
   logic        [LOG_B-1:0]  blocks_ff, blocks_in;
   logic signed [MTOT_W-1:0] mtot_ff, mtot_in;
   logic        [TOT_W-1:0]  vtot_ff, vtot_in;
   logic        [TOT_W-1:0]  ctot_ff, ctot_in;
   logic        [MTOT_W-1:0] mtot_mag;

   // divider operands
   logic [DIV_W-1:0] div_a_num, div_b_num, div_c_num;
   logic [DVS_W-1:0] div_a_den, div_b_den, div_c_den;
   logic [DIV_W-1:0] quo_a, quo_b, quo_c;
   logic             div_load;

   // pending result and output register
   logic                       pend_kind_ff, pend_empty_ff, pend_neg_ff;
   logic                       pend_kind_in, pend_empty_in, pend_neg_in;
   logic        [SAMPLE_W-1:0] mean_mag;
   logic signed [SAMPLE_W-1:0] mean_val;
   logic        [VAR_W-1:0]    var_val, varc_val;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_kind_ff, rsp_empty_ff;
   logic        [SAMPLE_W-1:0] rsp_mean_ff;
   logic        [VAR_W-1:0]    rsp_var_ff, rsp_varc_ff;

   assign sample    = signed'(req_tdata);
   assign sample_sq = sample * sample;

   // per-sample accumulation
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      sq_in  = sq_ff;
      if (cmd.accum) begin
         sum_in = sum_ff + SUM_W'(sample);
         sq_in  = sq_ff + SQ_W'(unsigned'(sample_sq));
         pos_in = status.block_full ? '0 : pos_ff + POS_W'(1);
      end
      if (cmd.capture || cmd.clear_block) begin
         pos_in = '0;
         sum_in = '0;
         sq_in  = '0;
      end
   end

   // magnitude square and n times sum of squares at block end
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mag_ff <= (sum_ff < 0) ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
         neg_ff <= sum_ff < 0;
         ssq_ff <= PROD_W'(sum_ff) * PROD_W'(sum_ff);
         nsq_ff <= PROD_W'(sq_ff) * PROD_W'(BLOCK_SIZE);
      end
   end

   assign diff     = (nsq_ff >= ssq_ff) ? nsq_ff - ssq_ff : '0;
   assign mtot_mag = (mtot_ff < 0) ? MTOT_W'(-mtot_ff) : MTOT_W'(mtot_ff);

   // divider operand selection
   always_comb begin
      if (cmd.load_final) begin
         div_a_num = DIV_W'(mtot_mag);
         div_b_num = DIV_W'(vtot_ff);
         div_c_num = DIV_W'(ctot_ff);
         div_a_den = DVS_W'(blocks_ff);
         div_b_den = DVS_W'(blocks_ff);
         div_c_den = DVS_W'(blocks_ff);
      end else begin
         div_a_num = DIV_W'(mag_ff);
         div_b_num = DIV_W'(diff);
         div_c_num = DIV_W'(diff);
         div_a_den = DVS_W'(BLOCK_SIZE);
         div_b_den = DVS_W'(N_SQ);
         div_c_den = DVS_W'(N_NM1);
      end
   end

   assign div_load = cmd.load_block || cmd.load_final;

   bmv_divider #(.DIV_W(DIV_W), .DVS_W(DVS_W)) div_mean (
      .clock    (clock),
      .load     (div_load),
      .step     (cmd.step),
      .dividend (div_a_num),
      .divisor  (div_a_den),
      .quotient (quo_a)
   );

   bmv_divider #(.DIV_W(DIV_W), .DVS_W(DVS_W)) div_var (
      .clock    (clock),
      .load     (div_load),
      .step     (cmd.step),
      .dividend (div_b_num),
      .divisor  (div_b_den),
      .quotient (quo_b)
   );

   bmv_divider #(.DIV_W(DIV_W), .DVS_W(DVS_W)) div_varc (
      .clock    (clock),
      .load     (div_load),
      .step     (cmd.step),
      .dividend (div_c_num),
      .divisor  (div_c_den),
      .quotient (quo_c)
   );

   // signed mean from magnitude quotient
   assign mean_mag = quo_a[SAMPLE_W-1:0];
   assign mean_val = pend_neg_ff ? signed'(-mean_mag) : signed'(mean_mag);
   assign var_val  = quo_b[VAR_W-1:0];
   assign varc_val = quo_c[VAR_W-1:0];

   // pending result attributes
   always_comb begin
      pend_kind_in  = pend_kind_ff;
      pend_empty_in = pend_empty_ff;
      pend_neg_in   = pend_neg_ff;
      if (cmd.load_block) begin
         pend_kind_in  = KIND_BLOCK;
         pend_empty_in = 1'b0;
         pend_neg_in   = neg_ff;
      end else if (cmd.load_final) begin
         pend_kind_in  = KIND_TOTAL;
         pend_empty_in = status.no_blocks;
         pend_neg_in   = mtot_ff < 0;
      end
   end

   // totals: add block results until MAX_BLOCKS blocks, clear on finish
   always_comb begin
      blocks_in = blocks_ff;
      mtot_in   = mtot_ff;
      vtot_in   = vtot_ff;
      ctot_in   = ctot_ff;
      if (cmd.load_final) begin
         blocks_in = '0;
         mtot_in   = '0;
         vtot_in   = '0;
         ctot_in   = '0;
      end else if (cmd.emit && pend_kind_ff == KIND_BLOCK &&
                   blocks_ff < LOG_B'(MAX_BLOCKS)) begin
         blocks_in = blocks_ff + LOG_B'(1);
         mtot_in   = mtot_ff + MTOT_W'(mean_val);
         vtot_in   = vtot_ff + TOT_W'(var_val);
         ctot_in   = ctot_ff + TOT_W'(varc_val);
      end
   end

   // output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         sum_ff        <= '0;
         sq_ff         <= '0;
         blocks_ff     <= '0;
         mtot_ff       <= '0;
         vtot_ff       <= '0;
         ctot_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_kind_ff  <= KIND_BLOCK;
         pend_empty_ff <= 1'b0;
         pend_neg_ff   <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         sum_ff        <= sum_in;
         sq_ff         <= sq_in;
         blocks_ff     <= blocks_in;
         mtot_ff       <= mtot_in;
         vtot_ff       <= vtot_in;
         ctot_ff       <= ctot_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_kind_ff  <= pend_kind_in;
         pend_empty_ff <= pend_empty_in;
         pend_neg_ff   <= pend_neg_in;
      end
   end

   // result payload, zeros when finish found no block
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff  <= pend_kind_ff;
         rsp_empty_ff <= pend_empty_ff;
         rsp_mean_ff  <= pend_empty_ff ? '0 : unsigned'(mean_val);
         rsp_var_ff   <= pend_empty_ff ? '0 : var_val;
         rsp_varc_ff  <= pend_empty_ff ? '0 : varc_val;
      end
   end

   assign status.block_full = pos_ff == POS_W'(BLOCK_SIZE - 1);
   assign status.no_blocks  = blocks_ff == '0;
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_varc_ff, rsp_var_ff, rsp_mean_ff};
   assign rsp_tuser  = {rsp_empty_ff, rsp_kind_ff};

endmodule

[design/bmv_controller.sv]
module bmv_controller import bmv_pkg::*; #(
   parameter int DIV_W = 41
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic           req_tuser,
   input  bmv_status_type status,
   output bmv_cmd_type    cmd
);

   localparam int CNT_W = $clog2(DIV_W);

   bmv_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cnt_in     = '0;
            if (req_tvalid) begin
               if (req_tuser == ACTION_FINISH) begin
                  cmd.clear_block = 1'b1;
                  cmd.load_final  = 1'b1;
                  state_in = status.no_blocks ? ST_EMIT : ST_DIVIDE;
               end else begin
                  cmd.accum = 1'b1;
                  if (status.block_full) begin
                     state_in = ST_CAPTURE;
                  end
               end
            end
         end
         ST_CAPTURE: begin
            cmd.capture = 1'b1;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_block = 1'b1;
            state_in       = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[design/block_mean_variance_core.sv]
// samples: one item per cycle while idle, no result until a block fills
// block end: CAPTURE, LOAD, DIVIDE, then EMIT after the last sample, W = dividend width
//   (41 at the defaults), divided by three shared restoring dividers, one bit a cycle
// finish: DIVIDE, then EMIT, or straight to EMIT when no block has completed
// no item is taken from block end or finish until its result sits in the output register
// reset: synchronous, clears accumulators, totals and the output valid
module block_mean_variance_core import bmv_pkg::*; #(
   parameter int BLOCK_SIZE = 9,
   parameter int MAX_BLOCKS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample
   input  logic                  req_tuser,   // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // mean, variance, variance_corrected
   output logic [RSP_USER_W-1:0] rsp_tuser    // kind, empty_res
);

   localparam int DIV_W = bmv_div_width(BLOCK_SIZE, MAX_BLOCKS);

   bmv_cmd_type    cmd;
   bmv_status_type status;

   bmv_controller #(.DIV_W(DIV_W)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   bmv_datapath #(.BLOCK_SIZE(BLOCK_SIZE), .MAX_BLOCKS(MAX_BLOCKS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[design/bmv_checker.sv]
module bmv_checker import bmv_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   // stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a block result never carries the empty flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == KIND_BLOCK |-> !rsp_tuser[1])
      else $error("empty flag on block result");

   // an empty finish reports zeros
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0] == KIND_TOTAL && rsp_tdata == '0)
      else $error("empty finish with nonzero values");

   // an accepted finish item takes the input out of ready
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ACTION_FINISH |=> !req_tready)
      else $error("input taken right after finish");

endmodule

bind block_mean_variance_core bmv_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import bmv_pkg::*;

   localparam int BLOCK_LEN      = 9;
   localparam int BLOCK_CAP      = 256;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 80;
   localparam int PRINT_CAP      = 40;

   // one input item as queued for the driver
   typedef struct {
      action_type          act;
      logic [SAMPLE_W-1:0] smp;
      int                  phase;
      bit                  drain;
      bit                  hold;
   } stream_item_t;

   // one result item
   typedef struct {
      kind_type            kind;
      logic                empty;
      logic [SAMPLE_W-1:0] mean;
      logic [VAR_W-1:0]    var_pop;
      logic [VAR_W-1:0]    var_corr;
   } block_stats_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // sample
   logic                  req_tuser = 1'b0; // action
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // mean, variance, variance_corrected
   logic [RSP_USER_W-1:0] rsp_tuser;        // kind, empty_res

   block_mean_variance_core #(
      .BLOCK_SIZE(BLOCK_LEN),
      .MAX_BLOCKS(BLOCK_CAP)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #5 clock = ~clock;

   // stimulus and expected results
   stream_item_t pending_items[$];
   block_stats_t stats_due[$];
   int           stats_issued = 0;
   int           stats_seen = 0;
   int           mismatch_count = 0;

   // idle rates per phase: sender then receiver
   int           send_idle_of[3] = '{22, 62, 0};
   int           recv_idle_of[3] = '{62, 22, 0};
   int           send_idle_pct = 22;
   int           recv_idle_pct = 62;

   logic         holdoff_kick = 1'b0;
   int           holdoff_left = 0;

   // coverage tallies for the summary
   int           samples_sent = 0;
   int           finishes_sent = 0;
   int           block_results = 0;
   int           total_results = 0;
   int           empty_results = 0;
   int           capped_blocks = 0;

   // predictor state for the running block and the totals
   logic [5:0]         fill_count = '0;
   logic signed [22:0] run_sum = '0;
   logic [36:0]        run_sqsum = '0;
   logic [8:0]         block_count = '0;
   logic signed [23:0] mean_total = '0;
   logic [39:0]        var_total = '0;
   logic [39:0]        var_corr_total = '0;

   // builder state
   int           queued_count = 0;
   int           build_phase = 0;
   bit           next_drain = 1'b0;
   bit           next_hold = 1'b0;

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP)
         $display("MISMATCH @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic clear_stats();
      fill_count = '0;
      run_sum = '0;
      run_sqsum = '0;
      block_count = '0;
      mean_total = '0;
      var_total = '0;
      var_corr_total = '0;
   endtask

   // expected result of one accepted item, updates the predictor state
   task automatic predict_stats(input action_type act, input logic [SAMPLE_W-1:0] smp,
                                output bit produced, output block_stats_t res);
      longint x;
      longint s1;
      longint s2;
      longint d;
      longint m;
      longint v;
      longint vc;
      longint b;
      produced = 1'b0;
      res = '{KIND_BLOCK, 1'b0, '0, '0, '0};
      if (act == ACTION_FINISH) begin
         produced = 1'b1;
         res.kind = KIND_TOTAL;
         if (block_count == 0) begin
            res.empty = 1'b1;
         end else begin
            b = longint'(block_count);
            m = longint'(mean_total) / b;
            res.mean = m[SAMPLE_W-1:0];
            v = longint'(var_total) / b;
            vc = longint'(var_corr_total) / b;
            res.var_pop = v[VAR_W-1:0];
            res.var_corr = vc[VAR_W-1:0];
         end
         clear_stats();
      end else begin
         x = longint'($signed(smp));
         run_sum = run_sum + x;
         run_sqsum = run_sqsum + x * x;
         fill_count = fill_count + 1;
         if (fill_count == BLOCK_LEN) begin
            s1 = longint'(run_sum);
            s2 = longint'(run_sqsum);
            m = s1 / BLOCK_LEN;
            d = BLOCK_LEN * s2 - s1 * s1;
            if (d < 0)
               d = 0;
            v = d / (BLOCK_LEN * BLOCK_LEN);
            vc = d / (BLOCK_LEN * (BLOCK_LEN - 1));
            // totals stop growing once the block count saturates
            if (block_count < BLOCK_CAP) begin
               block_count = block_count + 1;
               mean_total = mean_total + m;
               var_total = var_total + v;
               var_corr_total = var_corr_total + vc;
            end else begin
               capped_blocks++;
            end
            fill_count = '0;
            run_sum = '0;
            run_sqsum = '0;
            produced = 1'b1;
            res.mean = m[SAMPLE_W-1:0];
            res.var_pop = v[VAR_W-1:0];
            res.var_corr = vc[VAR_W-1:0];
         end
      end
   endtask

   task automatic queue_item(input action_type act, input logic [SAMPLE_W-1:0] smp);
      stream_item_t it;
      it.act = act;
      it.smp = smp;
      it.phase = build_phase;
      it.drain = next_drain;
      it.hold = next_hold;
      next_drain = 1'b0;
      next_hold = 1'b0;
      pending_items.push_back(it);
      queued_count++;
   endtask

   task automatic queue_finish();
      queue_item(ACTION_FINISH, SAMPLE_W'($urandom_range(0, 65535)));
   endtask

   // samples of one shape: spread, constant, clustered or rail to rail
   task automatic queue_samples(input int count);
      int                  mode;
      logic [SAMPLE_W-1:0] base;
      logic [SAMPLE_W-1:0] smp;
      mode = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
         0: base = 16'h7FFF;
         1: base = 16'h8000;
         2: base = 16'h0000;
         default: base = SAMPLE_W'($urandom_range(0, 65535));
      endcase
      for (int i = 0; i < count; i++) begin
         case (mode)
            0: smp = SAMPLE_W'($urandom_range(0, 65535));
            1: smp = base;
            2: smp = base + SAMPLE_W'($urandom_range(0, 64)) - 16'd32;
            default: smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         endcase
         queue_item(ACTION_SAMPLE, smp);
      end
   endtask

   // random traffic: mostly whole blocks ending in a finish, some broken runs
   task automatic queue_random_phase(input int phase, input int count);
      int stop_at;
      int pick;
      build_phase = phase;
      next_drain = 1'b1;
      stop_at = queued_count + count;
      while (queued_count < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            repeat ($urandom_range(1, 5))
               queue_samples(BLOCK_LEN);
            if ($urandom_range(0, 99) < 30)
               queue_samples($urandom_range(1, BLOCK_LEN - 1));
            queue_finish();
         end else if (pick < 90) begin
            queue_samples($urandom_range(1, BLOCK_LEN - 1));
            queue_finish();
         end else begin
            queue_finish();
         end
      end
   endtask

   // driver: offers queued items, predicts on every accepted one
   always @(posedge clock) begin : driver
      stream_item_t nxt;
      block_stats_t res;
      bit           produced;
      logic         offer;
      logic         kick;
      if (reset) begin
         req_tvalid <= 1'b0;
         holdoff_kick <= 1'b0;
      end else begin
         offer = req_tvalid;
         kick = 1'b0;
         if (req_tvalid && req_tready) begin
            predict_stats(action_type'(req_tuser), req_tdata, produced, res);
            if (req_tuser == ACTION_FINISH)
               finishes_sent++;
            else
               samples_sent++;
            if (produced) begin
               stats_due.push_back(res);
               stats_issued++;
            end
            offer = 1'b0;
         end
         if (!offer && pending_items.size() != 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = pending_items[0];
            // a drain item waits until every result is back
            if (!nxt.drain || stats_issued == stats_seen) begin
               void'(pending_items.pop_front());
               offer = 1'b1;
               kick = nxt.hold;
               req_tuser <= nxt.act;
               req_tdata <= nxt.smp;
               send_idle_pct = send_idle_of[nxt.phase];
               recv_idle_pct <= recv_idle_of[nxt.phase];
            end
         end
         req_tvalid <= offer;
         holdoff_kick <= kick;
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
      end else if (holdoff_kick) begin
         holdoff_left <= HOLDOFF_CYCLES;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // monitor: checks each accepted result against the oldest expectation
   always @(posedge clock) begin : monitor
      block_stats_t exp_res;
      kind_type     got_kind;
      logic         got_empty;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_kind = kind_type'(rsp_tuser[0]);
            got_empty = rsp_tuser[1];
            if (stats_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result tuser=%h tdata=%h",
                                         rsp_tuser, rsp_tdata));
            end else begin
               exp_res = stats_due.pop_front();
               if (got_kind !== exp_res.kind)
                  report_mismatch($sformatf("kind got %0d want %0d",
                                            got_kind, exp_res.kind));
               if (got_empty !== exp_res.empty)
                  report_mismatch($sformatf("empty got %b want %b",
                                            got_empty, exp_res.empty));
               if (rsp_tdata[SAMPLE_W-1:0] !== exp_res.mean)
                  report_mismatch($sformatf("mean got %h want %h",
                                            rsp_tdata[SAMPLE_W-1:0], exp_res.mean));
               if (rsp_tdata[SAMPLE_W +: VAR_W] !== exp_res.var_pop)
                  report_mismatch($sformatf("variance got %h want %h",
                                            rsp_tdata[SAMPLE_W +: VAR_W], exp_res.var_pop));
               if (rsp_tdata[SAMPLE_W + VAR_W +: VAR_W] !== exp_res.var_corr)
                  report_mismatch($sformatf("corrected variance got %h want %h",
                                            rsp_tdata[SAMPLE_W + VAR_W +: VAR_W],
                                            exp_res.var_corr));
               if (exp_res.kind == KIND_BLOCK)
                  block_results++;
               else
                  total_results++;
               if (exp_res.empty)
                  empty_results++;
            end
            stats_seen <= stats_seen + 1;
         end
         rsp_tready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // stimulus, reset and end of run
   initial begin
      // directed: empty finish, negative rail, rail to rail, dropped partial block
      build_phase = 0;
      queue_finish();
      repeat (BLOCK_LEN)
         queue_item(ACTION_SAMPLE, 16'h8000);
      for (int i = 0; i < BLOCK_LEN; i++)
         queue_item(ACTION_SAMPLE, (i % 2 == 0) ? 16'h8000 : 16'h7FFF);
      queue_item(ACTION_SAMPLE, 16'h0001);
      queue_item(ACTION_SAMPLE, 16'hFFFF);
      queue_item(ACTION_SAMPLE, 16'h0100);
      queue_finish();

      // receiver stalls for a long stretch while blocks keep coming
      next_hold = 1'b1;
      repeat (5)
         queue_samples(BLOCK_LEN);
      queue_finish();

      queue_random_phase(0, 420);
      queue_random_phase(1, 420);
      queue_random_phase(2, 420);

      // past the block count limit, then finish
      next_drain = 1'b1;
      repeat (BLOCK_CAP + 6)
         queue_samples(BLOCK_LEN);
      queue_samples(4);
      queue_finish();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_tvalid)
         @(negedge clock);
      while (stats_issued != stats_seen)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (stats_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", stats_due.size()));

      $display("Sent %0d samples and %0d finish items; checked %0d block results",
               samples_sent, finishes_sent, block_results);
      $display("and %0d overall reports (%0d empty); %0d blocks beyond the total cap",
               total_results, empty_results, capped_blocks);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("Timeout: %0d results outstanding", stats_issued - stats_seen);
      $display("Verification failed");
      $finish;
   end

endmodule
